// File: design/acp_pkg.sv
// Shared constants for the two-segment ADC calibrator.
`default_nettype none

package acp_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CAL_POINTS   = 3;
    localparam int CAL_DEPTH    = NUM_CHANNELS * CAL_POINTS;
    localparam int CAL_AW       = $clog2(CAL_DEPTH);

    localparam int CH_W    = 3;
    localparam int PT_W    = 2;
    localparam int CODE_W  = 24;
    localparam int FINE_W  = 31;
    localparam int MV_W    = 24;
    localparam int HUND_W  = 7;
    localparam int PACK_W  = 32;

    // request codes
    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    // calibration point codes; the fourth code names no point and its writes are dropped
    localparam logic [PT_W-1:0] PT_NEG    = 2'd0;
    localparam logic [PT_W-1:0] PT_ZERO   = 2'd1;
    localparam logic [PT_W-1:0] PT_POS    = 2'd2;
    localparam logic [PT_W-1:0] PT_UNUSED = 2'd3;

    // scaling: 6 V in 10 uV units
    localparam int                SCALE_W = 20;
    localparam logic [SCALE_W-1:0] SCALE_10UV = 20'd600000;

    // code differences are 25-bit signed, their magnitudes fit in 24 bits
    localparam int DIFF_W = CODE_W + 1;
    localparam int MAG_W  = CODE_W;
    localparam int NUM_W  = MAG_W + SCALE_W;
    localparam int CNT_W  = $clog2(NUM_W);

    // clipped magnitude of the fine value
    localparam int               QMAG_W     = 30;
    localparam logic [QMAG_W-1:0] FINE_LIMIT = 30'd838860799;

    // divide by 100 through a reciprocal: floor(a * RECIP / 2^37) for a < 2^30
    localparam int                RECIP_W     = 31;
    localparam logic [RECIP_W-1:0] RECIP_100   = 31'd1374389535;
    localparam int                RECIP_SHIFT = 37;
    localparam int                PROD_W      = QMAG_W + RECIP_W;
    localparam int                MVMAG_W     = 23;

endpackage

`default_nettype wire

// File: design/adc_piecewise_calibrator.sv
// Two-segment linear calibration of 24-bit ADC codes, with a shared iterative divider.
`default_nettype none

// A convert word on a valid channel holds busy high and raises its result strobe as
// the sequencer returns to idle; a zero segment span ends the sequence early, and an
// unknown channel gives its strobe without going busy. A write word gives no result.
// No word is taken while busy; the divider is a 44-step restoring one. Results cannot
// be stalled. Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
// the strobe; the calibration table is not cleared and must be written before use.
module adc_piecewise_calibrator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              req_type,
    input  wire logic [acp_pkg::CH_W-1:0]          channel,
    input  wire logic [acp_pkg::PT_W-1:0]          point_index,
    input  wire logic signed [acp_pkg::CODE_W-1:0] point_code,
    input  wire logic [acp_pkg::CODE_W-1:0]        raw_code,
    output logic                                   done,
    output logic [acp_pkg::CH_W-1:0]               channel_out,
    output logic signed [acp_pkg::FINE_W-1:0]      fine_value,
    output logic signed [acp_pkg::MV_W-1:0]        millivolts,
    output logic [acp_pkg::HUND_W-1:0]             hundredths,
    output logic signed [acp_pkg::PACK_W-1:0]      packed_value,
    output logic                                   span_zero,
    output logic                                   saturated
);
    import acp_pkg::*;

    // sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD_MID = 4'd1;
    localparam logic [3:0] S_RD_SEG = 4'd2;
    localparam logic [3:0] S_SPAN   = 4'd3;
    localparam logic [3:0] S_MUL    = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_SAT    = 4'd6;
    localparam logic [3:0] S_SCALE  = 4'd7;
    localparam logic [3:0] S_SPLIT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       done_reg, done_next;

    // calibration table, one row of three codes per channel
    logic signed [CODE_W-1:0] cal_mem [CAL_DEPTH];
    logic signed [CODE_W-1:0] rd_data_reg;
    logic [CAL_AW-1:0]        rd_addr;
    logic [CAL_AW-1:0]        wr_addr;
    logic [CAL_AW-1:0]        row_base;
    logic                     wr_en;

    // working registers
    logic signed [CODE_W-1:0] x_reg;
    logic signed [CODE_W-1:0] mid_reg;
    logic [CH_W-1:0]          ch_reg;
    logic                     upper_reg;
    logic [MAG_W-1:0]         diff_mag_reg;
    logic [MAG_W-1:0]         den_reg;
    logic                     neg_reg;
    logic [NUM_W-1:0]         quo_reg;
    logic [MAG_W-1:0]         rem_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [QMAG_W-1:0]        mag_reg;
    logic                     sat_reg;
    logic [PROD_W-1:0]        prod_reg;

    // result registers
    logic [CH_W-1:0]          ch_out_reg;
    logic signed [FINE_W-1:0] fine_reg;
    logic signed [MV_W-1:0]   mv_reg;
    logic [HUND_W-1:0]        hund_reg;
    logic signed [PACK_W-1:0] packed_reg;
    logic                     span_zero_reg;
    logic                     sat_out_reg;

    // combinational helpers
    logic                     accept;
    logic                     ch_ok;
    logic                     x_above_mid;
    logic signed [DIFF_W-1:0] diff_w;
    logic signed [DIFF_W-1:0] span_w;
    logic                     span_is_zero;
    logic [MAG_W:0]           trial_w;
    logic                     trial_ge;
    logic [MVMAG_W-1:0]       mv_mag_w;
    logic [HUND_W-1:0]        hund_w;
    logic signed [FINE_W-1:0] fine_w;
    logic signed [MV_W-1:0]   mv_w;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign ch_ok  = int'(channel) < NUM_CHANNELS;

    // table addressing: row = channel * 3, column = point
    assign wr_addr  = CAL_AW'(channel) * CAL_AW'(CAL_POINTS) + CAL_AW'(point_index);
    assign row_base = CAL_AW'(ch_reg) * CAL_AW'(CAL_POINTS);
    assign wr_en    = accept && (req_type == REQ_WRITE) && ch_ok && (point_index != PT_UNUSED);

    // while the zero code sits in the read register, pick the segment end to fetch
    assign x_above_mid = x_reg > rd_data_reg;

    always_comb
    begin
        case (state_reg)
            S_RD_SEG: rd_addr = row_base + CAL_AW'(x_above_mid ? PT_POS : PT_NEG);
            default:  rd_addr = row_base + CAL_AW'(PT_ZERO);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cal_mem[wr_addr] <= point_code;
        end
        rd_data_reg <= cal_mem[rd_addr];
    end

    // segment arithmetic, valid in S_SPAN when the segment end is in the read register
    assign diff_w = {x_reg[CODE_W-1], x_reg} - {mid_reg[CODE_W-1], mid_reg};
    assign span_w = upper_reg
                  ? ({rd_data_reg[CODE_W-1], rd_data_reg} - {mid_reg[CODE_W-1], mid_reg})
                  : ({mid_reg[CODE_W-1], mid_reg} - {rd_data_reg[CODE_W-1], rd_data_reg});
    assign span_is_zero = (span_w == '0);

    // one restoring divider step: shift in the next numerator bit, subtract if it fits
    assign trial_w  = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_ge = trial_w >= {1'b0, den_reg};

    // split the clipped magnitude into millivolts and hundredths
    assign mv_mag_w = prod_reg[RECIP_SHIFT +: MVMAG_W];
    assign hund_w   = HUND_W'(mag_reg - QMAG_W'(mv_mag_w) * QMAG_W'(100));
    assign fine_w   = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    assign mv_w     = neg_reg ? -$signed({1'b0, mv_mag_w}) : $signed({1'b0, mv_mag_w});

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_CONVERT))
                begin
                    if (ch_ok)
                    begin
                        state_next = S_RD_MID;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            S_RD_MID: state_next = S_RD_SEG;
            S_RD_SEG: state_next = S_SPAN;
            S_SPAN:
            begin
                if (span_is_zero)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL: state_next = S_DIV;
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:   state_next = S_SCALE;
            S_SCALE: state_next = S_SPLIT;
            S_SPLIT:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_CONVERT))
                begin
                    x_reg  <= signed'(raw_code);
                    ch_reg <= channel;
                    if (!ch_ok)
                    begin
                        // unknown channel: zero result with the zero-span flag
                        ch_out_reg    <= channel;
                        fine_reg      <= '0;
                        mv_reg        <= '0;
                        hund_reg      <= '0;
                        packed_reg    <= '0;
                        span_zero_reg <= 1'b1;
                        sat_out_reg   <= 1'b0;
                    end
                end
            end
            S_RD_SEG:
            begin
                mid_reg   <= rd_data_reg;
                upper_reg <= x_above_mid;
            end
            S_SPAN:
            begin
                diff_mag_reg <= MAG_W'(diff_w[DIFF_W-1] ? -diff_w : diff_w);
                den_reg      <= MAG_W'(span_w[DIFF_W-1] ? -span_w : span_w);
                neg_reg      <= diff_w[DIFF_W-1] ^ span_w[DIFF_W-1];
                if (span_is_zero)
                begin
                    ch_out_reg    <= ch_reg;
                    fine_reg      <= '0;
                    mv_reg        <= '0;
                    hund_reg      <= '0;
                    packed_reg    <= '0;
                    span_zero_reg <= 1'b1;
                    sat_out_reg   <= 1'b0;
                end
            end
            S_MUL:
            begin
                quo_reg <= NUM_W'(SCALE_10UV) * NUM_W'(diff_mag_reg);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg <= trial_ge ? MAG_W'(trial_w - {1'b0, den_reg}) : MAG_W'(trial_w);
                quo_reg <= {quo_reg[NUM_W-2:0], trial_ge};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            S_SAT:
            begin
                if (quo_reg > NUM_W'(FINE_LIMIT))
                begin
                    mag_reg <= FINE_LIMIT;
                    sat_reg <= 1'b1;
                end
                else
                begin
                    mag_reg <= quo_reg[QMAG_W-1:0];
                    sat_reg <= 1'b0;
                end
            end
            S_SCALE:
            begin
                prod_reg <= PROD_W'(mag_reg) * PROD_W'(RECIP_100);
            end
            S_SPLIT:
            begin
                ch_out_reg    <= ch_reg;
                fine_reg      <= fine_w;
                mv_reg        <= mv_w;
                hund_reg      <= hund_w;
                packed_reg    <= {mv_w, 1'b0, hund_w};
                span_zero_reg <= 1'b0;
                sat_out_reg   <= sat_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign done         = done_reg;
    assign channel_out  = ch_out_reg;
    assign fine_value   = fine_reg;
    assign millivolts   = mv_reg;
    assign hundredths   = hund_reg;
    assign packed_value = packed_reg;
    assign span_zero    = span_zero_reg;
    assign saturated    = sat_out_reg;

    // a result word only appears once the sequencer is back at rest
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while sequencer busy");

    // an accepted convert on a valid channel keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_CONVERT) && ch_ok) |=> busy)
        else $error("convert word accepted without entering the sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(span_zero && saturated))
        else $error("zero span and saturation flagged together");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hundredths < HUND_W'(100)))
        else $error("hundredths digits out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && span_zero) |-> (fine_value == '0 && packed_value == '0))
        else $error("zero span result carries a value");

endmodule

`default_nettype wire

// File: tb/tb_adc_piecewise_calibrator.sv
// Self-checking testbench for the two-segment ADC calibrator, with its own predictor and scoreboard.
`timescale 1ns / 1ps

module tb_adc_piecewise_calibrator;
    import acp_pkg::*;

    localparam longint FULL_SCALE   = 600000;      // 6 V in 10 uV steps
    localparam longint MAX_FINE     = 838860799;   // clip level of the fine value
    localparam longint CODE_MAX     = 8388607;
    localparam longint CODE_MIN     = -8388608;
    localparam int     RANDOM_WORDS = 1625;
    localparam int     DRAIN_EVERY  = 300;         // random words between forced drains
    localparam int     SETTLE       = 60;          // wait after the final drain
    localparam int     CYCLE_LIMIT  = 600000;

    typedef struct {
        logic [CH_W-1:0]          ch;
        logic signed [FINE_W-1:0] fine;
        logic signed [MV_W-1:0]   mv;
        logic [HUND_W-1:0]        hund;
        logic signed [PACK_W-1:0] pack_word;
        logic                     span_zero;
        logic                     sat;
    } cal_result_t;

    typedef struct {
        logic                     req;
        logic [CH_W-1:0]          ch;
        logic [PT_W-1:0]          pt;
        logic signed [CODE_W-1:0] code;
        logic [CODE_W-1:0]        raw;
        bit                       known;   // expected result typed into the table
        cal_result_t              res;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     req_type;
    logic [CH_W-1:0]          channel;
    logic [PT_W-1:0]          point_index;
    logic signed [CODE_W-1:0] point_code;
    logic [CODE_W-1:0]        raw_code;
    logic                     done;
    logic [CH_W-1:0]          channel_out;
    logic signed [FINE_W-1:0] fine_value;
    logic signed [MV_W-1:0]   millivolts;
    logic [HUND_W-1:0]        hundredths;
    logic signed [PACK_W-1:0] packed_value;
    logic                     span_zero;
    logic                     saturated;

    // Predictor state: our own copy of the calibration table, plus which entries
    // have been written, so that no convert ever reads an undefined entry.
    logic signed [CODE_W-1:0] cal_codes   [NUM_CHANNELS][CAL_POINTS];
    bit                       cal_written [NUM_CHANNELS][CAL_POINTS];

    cal_result_t pending_results[$];
    stim_row_t   stim_rows[$];

    int errors      = 0;
    int n_converts  = 0;
    int n_cal_store = 0;
    int n_sat       = 0;
    int n_span_zero = 0;
    int n_checked   = 0;
    int cycle_count = 0;

    adc_piecewise_calibrator dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Guard against a hung handshake: give up well beyond the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Two-segment calibration of one sample, computed with 64-bit integers.
    // Division in SystemVerilog truncates toward zero, which is what we want.
    function automatic cal_result_t calibrate_sample(input logic [CH_W-1:0] ch,
                                                     input logic [CODE_W-1:0] raw);
        cal_result_t r;
        longint      x, lo, mid, hi, span, q, mv, hund;
        r.ch        = ch;
        r.fine      = '0;
        r.mv        = '0;
        r.hund      = '0;
        r.pack_word = '0;
        r.span_zero = 1'b0;
        r.sat       = 1'b0;
        // An out-of-range channel reads as a zero span with all values zero.
        if (int'(ch) >= NUM_CHANNELS)
        begin
            r.span_zero = 1'b1;
            return r;
        end
        x    = $signed(raw);
        lo   = cal_codes[ch][PT_NEG];
        mid  = cal_codes[ch][PT_ZERO];
        hi   = cal_codes[ch][PT_POS];
        // Samples strictly above the zero code take the upper segment.
        span = (x > mid) ? hi - mid : mid - lo;
        if (span == 0)
        begin
            r.span_zero = 1'b1;
            return r;
        end
        q = (FULL_SCALE * (x - mid)) / span;
        if (q > MAX_FINE)
        begin
            q     = MAX_FINE;
            r.sat = 1'b1;
        end
        else if (q < -MAX_FINE)
        begin
            q     = -MAX_FINE;
            r.sat = 1'b1;
        end
        mv          = q / 100;
        hund        = ((q < 0) ? -q : q) % 100;
        r.fine      = q[FINE_W-1:0];
        r.mv        = mv[MV_W-1:0];
        r.hund      = hund[HUND_W-1:0];
        // The packed word keeps the low 24 bits of millivolts above the digits byte.
        r.pack_word = {mv[MV_W-1:0], 1'b0, hund[HUND_W-1:0]};
        return r;
    endfunction

    // Mostly back-to-back words, some short gaps, the odd long one; none at all when calm.
    function automatic int pick_gap(input bit calm);
        int sel;
        sel = $urandom_range(0, 19);
        if (calm || sel < 10)
            return 0;
        if (sel < 17)
            return $urandom_range(1, 3);
        if (sel < 19)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    task automatic add_write(input logic [CH_W-1:0] ch, input logic [PT_W-1:0] pt,
                             input logic signed [CODE_W-1:0] code);
        stim_row_t row;
        row.req   = REQ_WRITE;
        row.ch    = ch;
        row.pt    = pt;
        row.code  = code;
        row.raw   = '0;
        row.known = 1'b0;
        stim_rows.push_back(row);
    endtask

    task automatic add_convert(input logic [CH_W-1:0] ch, input logic [CODE_W-1:0] raw);
        stim_row_t row;
        row.req   = REQ_CONVERT;
        row.ch    = ch;
        row.pt    = PT_NEG;
        row.code  = '0;
        row.raw   = raw;
        row.known = 1'b0;
        stim_rows.push_back(row);
    endtask

    task automatic add_known(input logic [CH_W-1:0] ch, input logic [CODE_W-1:0] raw,
                             input int fine, input int mv, input int hund,
                             input logic [PACK_W-1:0] pack_word,
                             input logic sz, input logic sat);
        stim_row_t row;
        row.req           = REQ_CONVERT;
        row.ch            = ch;
        row.pt            = PT_NEG;
        row.code          = '0;
        row.raw           = raw;
        row.known         = 1'b1;
        row.res.ch        = ch;
        row.res.fine      = FINE_W'(fine);
        row.res.mv        = MV_W'(mv);
        row.res.hund      = HUND_W'(hund);
        row.res.pack_word = pack_word;
        row.res.span_zero = sz;
        row.res.sat       = sat;
        stim_rows.push_back(row);
    endtask

    // Present one word and hold it until the block takes it, then update the
    // table copy or queue the expected result. Start is left high on return.
    task automatic send_word(input stim_row_t row);
        cal_result_t res;
        start       <= 1'b1;
        req_type    <= row.req;
        channel     <= row.ch;
        point_index <= row.pt;
        point_code  <= row.code;
        raw_code    <= row.raw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (row.req == REQ_WRITE)
        begin
            // Drop writes to point index three or to a channel that does not exist.
            if (row.pt < CAL_POINTS && int'(row.ch) < NUM_CHANNELS)
            begin
                cal_codes[row.ch][row.pt]   = row.code;
                cal_written[row.ch][row.pt] = 1'b1;
                n_cal_store++;
            end
        end
        else
        begin
            res = row.known ? row.res : calibrate_sample(row.ch, row.raw);
            pending_results.push_back(res);
            n_converts++;
            if (res.sat)
                n_sat++;
            if (res.span_zero)
                n_span_zero++;
        end
    endtask

    // Lower start for a while and put junk on the idle payload.
    task automatic idle(input int cycles);
        if (cycles > 0)
        begin
            start       <= 1'b0;
            req_type    <= 1'($urandom);
            channel     <= CH_W'($urandom);
            point_index <= PT_W'($urandom);
            point_code  <= CODE_W'($urandom);
            raw_code    <= CODE_W'($urandom);
            repeat (cycles)
                @(posedge clk);
        end
    endtask

    // Hold off the sender until every expected result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Scoreboard: match every strobed result against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        cal_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result on channel %0d, fine value %0d",
                         $time, channel_out, fine_value);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                check_field("channel_out", want.ch, channel_out);
                check_field("fine_value", want.fine, fine_value);
                check_field("millivolts", want.mv, millivolts);
                check_field("hundredths", want.hund, hundredths);
                check_field("packed_value", want.pack_word, packed_value);
                check_field("span_zero", want.span_zero, span_zero);
                check_field("saturated", want.sat, saturated);
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t row;
        longint    v;
        longint    mid;
        int        sel;
        int        counted;
        int        n;
        bit        calm;

        start       <= 1'b0;
        rst_n       <= 1'b0;
        req_type    <= REQ_WRITE;
        channel     <= '0;
        point_index <= PT_NEG;
        point_code  <= '0;
        raw_code    <= '0;
        foreach (cal_codes[c, p])
        begin
            cal_codes[c][p]   = '0;
            cal_written[c][p] = 1'b0;
        end

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Channel 0 is a plain symmetric calibration; the write to
        // point index three must leave it alone, which the first convert shows.
        add_write(3'd0, PT_NEG, -24'sd4000000);
        add_write(3'd0, PT_ZERO, 24'sd0);
        add_write(3'd0, PT_POS, 24'sd4000000);
        add_write(3'd0, PT_UNUSED, 24'sh7FFFFF);
        add_known(3'd0, 24'h3D0900, 600000, 6000, 0, 32'sd1536000, 1'b0, 1'b0);
        // A sample equal to the zero code falls into the lower segment.
        add_known(3'd0, 24'h000000, 0, 0, 0, 32'sd0, 1'b0, 1'b0);
        add_known(3'd0, 24'hC2F700, -600000, -6000, 0, -32'sd1536000, 1'b0, 1'b0);
        add_convert(3'd0, 24'h7FFFFF);
        add_convert(3'd0, 24'h800000);
        add_convert(3'd0, 24'h000001);
        // Channel 1: all points equal, so both segments have a zero span.
        add_write(3'd1, PT_NEG, 24'sd100);
        add_write(3'd1, PT_ZERO, 24'sd100);
        add_write(3'd1, PT_POS, 24'sd100);
        add_known(3'd1, 24'h000064, 0, 0, 0, 32'sd0, 1'b1, 1'b0);
        add_known(3'd1, 24'hFFFFFF, 0, 0, 0, 32'sd0, 1'b1, 1'b0);
        add_known(3'd1, 24'h7FFFFF, 0, 0, 0, 32'sd0, 1'b1, 1'b0);
        // Channel 2: spans of one code, so full-scale samples clip both ways.
        add_write(3'd2, PT_NEG, -24'sd1);
        add_write(3'd2, PT_ZERO, 24'sd0);
        add_write(3'd2, PT_POS, 24'sd1);
        add_known(3'd2, 24'h7FFFFF, 838860799, 8388607, 99, 32'h7FFFFF63, 1'b0, 1'b1);
        add_known(3'd2, 24'h800000, -838860799, -8388607, 99, 32'h80000163, 1'b0, 1'b1);
        // Channel 3: calibration points at the code extremes.
        add_write(3'd3, PT_NEG, 24'sh800000);
        add_write(3'd3, PT_ZERO, 24'sd0);
        add_write(3'd3, PT_POS, 24'sh7FFFFF);
        add_known(3'd3, 24'h7FFFFF, 600000, 6000, 0, 32'sd1536000, 1'b0, 1'b0);
        add_known(3'd3, 24'h800000, -600000, -6000, 0, -32'sd1536000, 1'b0, 1'b0);

        foreach (stim_rows[i])
        begin
            send_word(stim_rows[i]);
            idle(pick_gap(1'b0));
        end

        // Random part. A channel is converted only once all three of its points
        // are written; until then the word becomes a write to that channel.
        counted = 0;
        calm    = 1'b0;
        for (n = 0; counted < RANDOM_WORDS; n++)
        begin
            // Flip now and then into a stretch of back-to-back words.
            if ($urandom_range(0, 99) == 0)
                calm = !calm;
            row.ch    = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
            row.code  = CODE_W'($urandom);
            row.raw   = CODE_W'($urandom);
            row.known = 1'b0;
            mid       = cal_codes[row.ch][PT_ZERO];
            sel       = $urandom_range(0, 9);
            if (!(cal_written[row.ch][PT_NEG] && cal_written[row.ch][PT_ZERO]
                  && cal_written[row.ch][PT_POS]) || $urandom_range(0, 4) == 0)
            begin
                row.req = REQ_WRITE;
                row.pt  = ($urandom_range(0, 15) == 0) ? PT_UNUSED
                                                       : PT_W'($urandom_range(0, 2));
                // Codes: plausible per point, some narrow spans for clipping,
                // copies of another point for zero spans, extremes, and pure noise.
                v = $signed(row.code);
                if (sel >= 2 && sel <= 4)
                begin
                    if (row.pt == PT_NEG)
                        v = -longint'($urandom_range(8388608, 1000));
                    else if (row.pt == PT_ZERO)
                        v = longint'($urandom_range(0, 4000)) - 2000;
                    else
                        v = $urandom_range(8388607, 1000);
                end
                else if (sel == 5 || sel == 6)
                begin
                    v = $urandom_range(1, 3000);
                    v = (row.pt == PT_NEG) ? mid - v : mid + v;
                end
                else if (sel == 7)
                    v = cal_codes[row.ch][$urandom_range(0, 2)];
                else if (sel >= 8)
                begin
                    case ($urandom_range(0, 3))
                        0: v = CODE_MIN;
                        1: v = CODE_MAX;
                        2: v = 0;
                        default: v = -1;
                    endcase
                end
                v        = (v > CODE_MAX) ? CODE_MAX : (v < CODE_MIN) ? CODE_MIN : v;
                row.code = v[CODE_W-1:0];
            end
            else
            begin
                row.req = REQ_CONVERT;
                row.pt  = PT_W'($urandom);
                // Samples: half full-range noise, the rest at or near segment edges, or extremes.
                v = $signed(row.raw);
                if (sel == 5 || sel == 6)
                    v = mid + longint'($urandom_range(0, 10000)) - 5000;
                else if (sel == 7)
                    v = mid;
                else if (sel == 8)
                begin
                    case ($urandom_range(0, 3))
                        0: v = CODE_MIN;
                        1: v = CODE_MAX;
                        2: v = 0;
                        default: v = -1;
                    endcase
                end
                else if (sel == 9)
                    v = cal_codes[row.ch][($urandom_range(0, 1) == 0) ? PT_NEG : PT_POS]
                        + longint'($urandom_range(0, 200)) - 100;
                v       = (v > CODE_MAX) ? CODE_MAX : (v < CODE_MIN) ? CODE_MIN : v;
                row.raw = v[CODE_W-1:0];
            end
            // Dropped writes do not count toward the random total.
            if (row.req == REQ_CONVERT || row.pt != PT_UNUSED)
                counted++;
            send_word(row);
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain_results();
            else
                idle(pick_gap(calm));
        end

        drain_results();
        repeat (SETTLE)
            @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            errors++;
        end

        $display("Ran %0d conversions (%0d clipped, %0d zero-span) and %0d table stores.",
                 n_converts, n_sat, n_span_zero, n_cal_store);
        $display("Compared %0d results over %0d cycles, %0d errors.",
                 n_checked, cycle_count, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
